/* hdl/assert_macros.svh */
// Assertion macros shared by the playout scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define APSS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every clock edge, reset included.
`define APSS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/apss_pkg.sv */
// Package of types, constants and codes for the audio playout scheduler.
`default_nettype none

package apss_pkg;

    // Scheduling parameters, in stereo frames
    localparam int MIN_QUEUED_FRAMES = 5500;
    localparam int JITTER_FRAMES     = 120;
    localparam int DMA_BUFFER_FRAMES = 1000;
    localparam int DMA_BUFFERS       = 16;
    localparam int MAX_CHUNK_FRAMES  = 3840;

    // Rate and scaling constants
    localparam longint SAMPLE_RATE_HZ = 48000;
    localparam longint US_PER_SECOND  = 1000000;
    localparam longint US_PER_MS      = 1000;
    localparam longint PERCENT_SCALE  = 100;
    localparam longint EXTRA_ATTEN    = 8;
    localparam longint PENDING_MAX    = 65535;

    // Field widths
    localparam int CFG_W       = 14;
    localparam int CFG_IDX_W   = 3;
    localparam int VOL_W       = 7;
    localparam int CMD_W       = 2;
    localparam int TIME_W      = 32;
    localparam int COUNT_W     = 12;
    localparam int SAMPLE_W    = 16;
    localparam int VERDICT_W   = 3;
    localparam int PEND_W      = 16;
    localparam int IN_DATA_W   = 80;
    localparam int OUT_DATA_W  = 80;

    // Queue estimate after reset, saturated to the counter range
    localparam longint PENDING_RESET_RAW = longint'(DMA_BUFFERS) * longint'(DMA_BUFFER_FRAMES);
    localparam longint PENDING_RESET =
        (PENDING_RESET_RAW > PENDING_MAX) ? PENDING_MAX : PENDING_RESET_RAW;

    // Greatest common divisor by repeated subtraction, for elaboration only
    function automatic longint gcd_f(longint a, longint b);
        longint x;
        longint y;
        x = a;
        y = b;
        while (x != y) begin
            if (x > y)
                x = x - y;
            else
                y = y - x;
        end
        return x;
    endfunction

    // Offset in microseconds to offset in frames: times RATE_NUM over RATE_DEN
    localparam longint RATE_GCD = gcd_f(SAMPLE_RATE_HZ, US_PER_SECOND);
    localparam longint RATE_NUM = SAMPLE_RATE_HZ / RATE_GCD;
    localparam longint RATE_DEN = US_PER_SECOND / RATE_GCD;

    // Largest offset in frames that is not deferred
    localparam longint OFF_LIMIT = longint'(MIN_QUEUED_FRAMES) + longint'(JITTER_FRAMES);

    // Offset arithmetic widths
    localparam int DIFF_W    = CFG_W + 1;
    localparam int DIFF_US_W = DIFF_W + $clog2(US_PER_MS + 1);
    localparam int OFFUS_W   = TIME_W + 2;

    // Clamp of the microsecond offset: anything at or above the top is deferred
    localparam int     CLAMP_W   = $clog2(((OFF_LIMIT + 1) * RATE_DEN) / RATE_NUM + 2);
    localparam longint CLAMP_TOP = longint'(1) << CLAMP_W;

    // Offsets at or below minus LATE_US microseconds give a negative frame offset
    localparam longint LATE_US = (RATE_DEN + RATE_NUM - 1) / RATE_NUM;

    // Exact reciprocal for the frame conversion
    localparam int     RATE_IN_W   = CLAMP_W + $clog2(RATE_NUM);
    localparam int     RATE_SHIFT  = RATE_IN_W + $clog2(RATE_DEN);
    localparam longint RATE_RECIP  = ((longint'(1) << RATE_SHIFT) + RATE_DEN - 1) / RATE_DEN;
    localparam longint RATE_K      = RATE_NUM * RATE_RECIP;
    localparam int     RATE_PROD_W = RATE_SHIFT + CLAMP_W;

    // Exact reciprocal for the volume scaling: divide magnitude by percent and attenuation
    localparam longint SCALE_DIV    = PERCENT_SCALE * EXTRA_ATTEN;
    localparam int     PROD_W       = SAMPLE_W + VOL_W + 1;
    localparam int     MAG_W        = SAMPLE_W + VOL_W - 1;
    localparam int     SCALE_SHIFT  = MAG_W + $clog2(SCALE_DIV);
    localparam longint SCALE_RECIP  = ((longint'(1) << SCALE_SHIFT) + SCALE_DIV - 1) / SCALE_DIV;
    localparam int     SCALE_PROD_W = SCALE_SHIFT + SAMPLE_W;

    // Width for frame comparisons in the scheduler
    localparam int CMP_W = ((CLAMP_W > PEND_W) ? CLAMP_W : PEND_W) + 2;

    typedef logic        [CFG_W-1:0]        cfgval_t;
    typedef logic        [VOL_W-1:0]        vol_t;
    typedef logic        [COUNT_W-1:0]      count_t;
    typedef logic        [PEND_W-1:0]       pend_t;
    typedef logic signed [SAMPLE_W-1:0]     sample_t;
    typedef logic signed [TIME_W-1:0]       time_t;
    typedef logic signed [DIFF_W-1:0]       diff_t;
    typedef logic signed [DIFF_US_W-1:0]    diff_us_t;
    typedef logic signed [OFFUS_W-1:0]      offus_t;
    typedef logic        [CLAMP_W-1:0]      clamp_t;
    typedef logic        [RATE_PROD_W-1:0]  rate_prod_t;
    typedef logic signed [PROD_W-1:0]       prod_t;
    typedef logic        [MAG_W-1:0]        mag_t;
    typedef logic        [SCALE_PROD_W-1:0] scale_prod_t;
    typedef logic        [CMP_W-1:0]        cmp_t;

    // Input commands
    typedef enum logic [CMD_W-1:0] {
        CMD_DMA_DONE    = 2'd0,
        CMD_HEADER      = 2'd1,
        CMD_FRAME       = 2'd2,
        CMD_SERVICE_END = 2'd3
    } cmd_t;

    // Result kinds
    typedef enum logic [CMD_W-1:0] {
        KIND_DMA_STATUS   = 2'd0,
        KIND_VERDICT      = 2'd1,
        KIND_FRAME        = 2'd2,
        KIND_SERVICE_FILL = 2'd3
    } kind_t;

    // Chunk verdicts
    typedef enum logic [VERDICT_W-1:0] {
        V_PLAY      = 3'd0,
        V_LATE      = 3'd1,
        V_DEFER     = 3'd2,
        V_TRIM_FAIL = 3'd3,
        V_HOLD      = 3'd4
    } verdict_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BUFFER_TIME = 3'd0,
        REG_LATENCY     = 3'd1,
        REG_VOLUME      = 3'd2,
        REG_MUTE        = 3'd3,
        REG_TIME_SYNCED = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        cfgval_t buffer_time_ms;
        cfgval_t latency_ms;
        vol_t    volume_percent;
        logic    mute;
        logic    time_synced;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        buffer_time_ms: '0,
        latency_ms:     '0,
        volume_percent: '0,
        mute:           1'b1,
        time_synced:    1'b0
    };

    // Chunk offset as seen by the scheduler
    typedef struct packed {
        logic   late;
        clamp_t off;
    } off_res_t;

    // One result item
    typedef struct packed {
        kind_t    kind;
        verdict_t verdict;
        pend_t    zero_frames;
        count_t   trimmed_frames;
        sample_t  left_out;
        sample_t  right_out;
        logic     underrun;
        pend_t    queued_frames;
    } res_t;

endpackage

`default_nettype wire

/* hdl/apss_offset.sv */
// Two-stage conversion of a chunk's play time into a clamped frame offset.
`default_nettype none

module apss_offset (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire apss_pkg::time_t   time_us,
    input  wire apss_pkg::cfg_t    cfg,
    output apss_pkg::off_res_t     res
);

    apss_pkg::diff_t      diff;
    apss_pkg::diff_us_t   diff_us;
    apss_pkg::offus_t     off_us;
    logic                 late_next;
    apss_pkg::clamp_t     clamp_next;
    logic                 late_reg;
    apss_pkg::clamp_t     clamp_reg;
    apss_pkg::rate_prod_t rate_prod;
    apss_pkg::off_res_t   res_next;
    apss_pkg::off_res_t   res_reg;

    // Form the offset in microseconds, flag late chunks and clamp the rest
    always_comb
    begin
        diff    = apss_pkg::diff_t'({1'b0, cfg.buffer_time_ms})
                - apss_pkg::diff_t'({1'b0, cfg.latency_ms});
        diff_us = apss_pkg::diff_us_t'(diff) * apss_pkg::diff_us_t'(apss_pkg::US_PER_MS);
        off_us  = apss_pkg::offus_t'(diff_us) + apss_pkg::offus_t'(time_us);
        late_next = (off_us <= apss_pkg::offus_t'(-apss_pkg::LATE_US));
        if (off_us[apss_pkg::OFFUS_W-1])
            clamp_next = '0;
        else if (off_us >= apss_pkg::offus_t'(apss_pkg::CLAMP_TOP))
            clamp_next = '1;
        else
            clamp_next = off_us[apss_pkg::CLAMP_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            late_reg  <= late_next;
            clamp_reg <= clamp_next;
        end
    end

    // Scale microseconds to frames by the exact reciprocal
    always_comb
    begin
        rate_prod = apss_pkg::rate_prod_t'(clamp_reg)
                  * apss_pkg::rate_prod_t'(apss_pkg::RATE_K);
        res_next.late = late_reg;
        res_next.off  = rate_prod[apss_pkg::RATE_SHIFT +: apss_pkg::CLAMP_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

/* hdl/apss_lane.sv */
// Two-stage volume scaler for one channel of a stereo frame.
`default_nettype none

module apss_lane (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire apss_pkg::sample_t sample,
    input  wire apss_pkg::vol_t    volume,
    output apss_pkg::sample_t      scaled
);

    apss_pkg::prod_t       prod;
    logic                  neg_next;
    apss_pkg::mag_t        mag_next;
    logic                  neg_reg;
    apss_pkg::mag_t        mag_reg;
    apss_pkg::scale_prod_t scale_prod;
    logic [apss_pkg::SAMPLE_W-1:0] quot;
    apss_pkg::sample_t     scaled_next;
    apss_pkg::sample_t     scaled_reg;

    // Multiply by volume and split into sign and magnitude
    always_comb
    begin
        prod     = apss_pkg::prod_t'(sample) * apss_pkg::prod_t'({1'b0, volume});
        neg_next = prod[apss_pkg::PROD_W-1];
        mag_next = neg_next ? apss_pkg::mag_t'(-prod) : apss_pkg::mag_t'(prod);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg <= neg_next;
            mag_reg <= mag_next;
        end
    end

    // Divide the magnitude by percent and attenuation, then restore the sign
    always_comb
    begin
        scale_prod  = apss_pkg::scale_prod_t'(mag_reg)
                    * apss_pkg::scale_prod_t'(apss_pkg::SCALE_RECIP);
        quot        = scale_prod[apss_pkg::SCALE_SHIFT +: apss_pkg::SAMPLE_W];
        scaled_next = neg_reg ? apss_pkg::sample_t'(-quot) : apss_pkg::sample_t'(quot);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            scaled_reg <= scaled_next;
    end

    assign scaled = scaled_reg;

endmodule

`default_nettype wire

/* hdl/apss_sched.sv */
// Scheduler stage: queue estimate, chunk verdicts, frame gating and the output register.
`default_nettype none

module apss_sched (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               valid,
    input  wire apss_pkg::cmd_t     cmd,
    input  wire apss_pkg::count_t   count,
    input  wire apss_pkg::off_res_t off,
    input  wire apss_pkg::sample_t  left,
    input  wire apss_pkg::sample_t  right,
    input  wire apss_pkg::cfg_t     cfg,
    output logic                    out_valid,
    output apss_pkg::res_t          res
);

    apss_pkg::pend_t  pending_reg;
    apss_pkg::pend_t  pending_next;
    apss_pkg::count_t left_reg;
    apss_pkg::count_t left_next;
    apss_pkg::count_t skip_reg;
    apss_pkg::count_t skip_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    apss_pkg::res_t   res_reg;
    apss_pkg::res_t   res_next;
    logic             emit;
    apss_pkg::count_t n_clamp;
    apss_pkg::cmp_t   pend_c;
    apss_pkg::cmp_t   off_c;
    apss_pkg::cmp_t   skip_c;

    // Decide the result of the item in the last stage and the new state
    always_comb
    begin
        pending_next = pending_reg;
        left_next    = left_reg;
        skip_next    = skip_reg;
        res_next     = '0;
        res_next.kind = apss_pkg::kind_t'(cmd);
        emit         = 1'b1;
        n_clamp = (count > apss_pkg::count_t'(apss_pkg::MAX_CHUNK_FRAMES))
                ? apss_pkg::count_t'(apss_pkg::MAX_CHUNK_FRAMES) : count;
        pend_c  = apss_pkg::cmp_t'(pending_reg);
        off_c   = apss_pkg::cmp_t'(off.off);
        skip_c  = pend_c - off_c;

        case (cmd)
            apss_pkg::CMD_DMA_DONE:
            begin
                // Drop one buffer, clamp on underrun
                if (pending_reg <= apss_pkg::pend_t'(apss_pkg::DMA_BUFFER_FRAMES))
                begin
                    pending_next      = apss_pkg::pend_t'(apss_pkg::DMA_BUFFER_FRAMES);
                    res_next.underrun = 1'b1;
                end
                else
                begin
                    pending_next = pending_reg - apss_pkg::pend_t'(apss_pkg::DMA_BUFFER_FRAMES);
                end
            end
            apss_pkg::CMD_HEADER:
            begin
                // Forget the previous chunk, then rule on this one
                left_next = '0;
                skip_next = '0;
                if (!cfg.time_synced
                    || pending_reg >= apss_pkg::pend_t'(apss_pkg::MIN_QUEUED_FRAMES))
                begin
                    res_next.verdict = apss_pkg::V_HOLD;
                end
                else if (off.late)
                begin
                    res_next.verdict = apss_pkg::V_LATE;
                end
                else if (off_c > apss_pkg::cmp_t'(apss_pkg::OFF_LIMIT))
                begin
                    res_next.verdict = apss_pkg::V_DEFER;
                end
                else if (pend_c + apss_pkg::cmp_t'(apss_pkg::JITTER_FRAMES) < off_c)
                begin
                    // Pad with zeros up to the chunk's offset
                    res_next.verdict     = apss_pkg::V_PLAY;
                    res_next.zero_frames = apss_pkg::pend_t'(off_c - pend_c);
                    pending_next         = off_c[apss_pkg::PEND_W-1:0];
                    left_next            = n_clamp;
                end
                else if (pend_c > off_c + apss_pkg::cmp_t'(apss_pkg::JITTER_FRAMES))
                begin
                    // Trim leading frames unless the whole chunk would go
                    if (skip_c >= apss_pkg::cmp_t'(n_clamp))
                    begin
                        res_next.verdict = apss_pkg::V_TRIM_FAIL;
                    end
                    else
                    begin
                        res_next.verdict        = apss_pkg::V_PLAY;
                        res_next.trimmed_frames = skip_c[apss_pkg::COUNT_W-1:0];
                        skip_next               = skip_c[apss_pkg::COUNT_W-1:0];
                        left_next               = n_clamp - skip_c[apss_pkg::COUNT_W-1:0];
                    end
                end
                else
                begin
                    res_next.verdict = apss_pkg::V_PLAY;
                    left_next        = n_clamp;
                end
            end
            apss_pkg::CMD_FRAME:
            begin
                // Count down trimmed frames, drop stray ones, pass the rest
                if (skip_reg != '0)
                begin
                    skip_next = skip_reg - 1'b1;
                    emit      = 1'b0;
                end
                else if (left_reg == '0)
                begin
                    emit = 1'b0;
                end
                else
                begin
                    left_next          = left_reg - 1'b1;
                    res_next.left_out  = cfg.mute ? '0 : left;
                    res_next.right_out = cfg.mute ? '0 : right;
                    if (pending_reg != apss_pkg::pend_t'(apss_pkg::PENDING_MAX))
                        pending_next = pending_reg + 1'b1;
                end
            end
            apss_pkg::CMD_SERVICE_END:
            begin
                // Top the queue up with zeros
                if (pending_reg < apss_pkg::pend_t'(apss_pkg::MIN_QUEUED_FRAMES))
                begin
                    res_next.zero_frames = apss_pkg::pend_t'(apss_pkg::MIN_QUEUED_FRAMES)
                                         - pending_reg;
                    pending_next         = apss_pkg::pend_t'(apss_pkg::MIN_QUEUED_FRAMES);
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        res_next.queued_frames = pending_next;
        out_valid_next         = valid && emit;
    end

    // Advance state on an item in the last stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= apss_pkg::pend_t'(apss_pkg::PENDING_RESET);
            left_reg      <= '0;
            skip_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= out_valid_next;
            if (valid)
            begin
                pending_reg <= pending_next;
                left_reg    <= left_next;
                skip_reg    <= skip_next;
            end
        end
    end

    // Load the output register whenever it is free or being taken
    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

/* hdl/audio_playout_sync_scheduler_unit.sv */
// Audio playout scheduler. Takes one item per clock on the s_ stream unless stalled and gives
// at most one result per item on the m_ stream: two stages convert a chunk's play time into
// a frame offset while two parallel lanes scale the left and right samples, and a final
// stage updates the queue estimate and chunk counters and loads the output register. That
// state update is done within the final stage alone, so a new item can enter every cycle;
// the whole pipeline stalls only while a result sits unaccepted in the output register.
// DMA-done ticks, service ends and chunk headers always give a result; a stereo frame gives
// one only when it belongs to a played chunk and is not trimmed. Write the configuration
// registers only while no item is in flight.
`default_nettype none

module audio_playout_sync_scheduler_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // time_to_play_us[31:0], frame_count[43:32], left_in[59:44], right_in[75:60], zero[79:76]
    input  wire logic [79:0] s_tdata,
    // command[1:0]
    input  wire logic [1:0]  s_tuser,
    // Result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // verdict[2:0], zero_frames[18:3], trimmed_frames[30:19], left_out[46:31],
    // right_out[62:47], underrun[63], queued_frames[79:64]
    output logic [79:0]      m_tdata,
    // result_kind[1:0]
    output logic [1:0]       m_tuser,
    // Configuration writes
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [13:0] cfg_data
);

    `include "assert_macros.svh"

    apss_pkg::cfg_t     cfg_reg;
    apss_pkg::cfg_t     cfg_next;
    logic               en;
    logic               accept;
    logic               v1_reg;
    logic               v2_reg;
    apss_pkg::cmd_t     cmd1_reg;
    apss_pkg::cmd_t     cmd2_reg;
    apss_pkg::count_t   cnt1_reg;
    apss_pkg::count_t   cnt2_reg;
    apss_pkg::off_res_t off;
    apss_pkg::sample_t  left_scaled;
    apss_pkg::sample_t  right_scaled;
    logic               out_valid;
    apss_pkg::res_t     res;

    // Apply configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (apss_pkg::cfg_reg_t'(cfg_index))
                apss_pkg::REG_BUFFER_TIME: cfg_next.buffer_time_ms = cfg_data;
                apss_pkg::REG_LATENCY:     cfg_next.latency_ms     = cfg_data;
                apss_pkg::REG_VOLUME:      cfg_next.volume_percent = cfg_data[apss_pkg::VOL_W-1:0];
                apss_pkg::REG_MUTE:        cfg_next.mute           = cfg_data[0];
                apss_pkg::REG_TIME_SYNCED: cfg_next.time_synced    = cfg_data[0];
                default:                   cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= apss_pkg::CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    // Advance the pipeline whenever the output register is free or being taken
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    // Track item validity through the two arithmetic stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
        end
    end

    // Carry command and frame count alongside
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd1_reg <= apss_pkg::cmd_t'(s_tuser);
            cnt1_reg <= s_tdata[43:32];
            cmd2_reg <= cmd1_reg;
            cnt2_reg <= cnt1_reg;
        end
    end

    apss_offset u_offset (
        .clk     (clk),
        .en      (en),
        .time_us (apss_pkg::time_t'(s_tdata[31:0])),
        .cfg     (cfg_reg),
        .res     (off)
    );

    apss_lane u_lane_left (
        .clk    (clk),
        .en     (en),
        .sample (apss_pkg::sample_t'(s_tdata[59:44])),
        .volume (cfg_reg.volume_percent),
        .scaled (left_scaled)
    );

    apss_lane u_lane_right (
        .clk    (clk),
        .en     (en),
        .sample (apss_pkg::sample_t'(s_tdata[75:60])),
        .volume (cfg_reg.volume_percent),
        .scaled (right_scaled)
    );

    apss_sched u_sched (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid     (v2_reg),
        .cmd       (cmd2_reg),
        .count     (cnt2_reg),
        .off       (off),
        .left      (left_scaled),
        .right     (right_scaled),
        .cfg       (cfg_reg),
        .out_valid (out_valid),
        .res       (res)
    );

    // Pack the result item
    assign m_tvalid = out_valid;
    assign m_tuser  = res.kind;
    assign m_tdata  = {res.queued_frames, res.underrun, res.right_out, res.left_out,
                       res.trimmed_frames, res.zero_frames, res.verdict};

    // Nothing is in flight while reset is held
    `APSS_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !m_tvalid && !v1_reg && !v2_reg, "pipeline not empty in reset")

    // A service end leaves the queue at least at its minimum
    `APSS_ASSERT(a_service_fill, m_tvalid && res.kind == apss_pkg::KIND_SERVICE_FILL |-> res.queued_frames >= apss_pkg::pend_t'(apss_pkg::MIN_QUEUED_FRAMES), "service fill below minimum")

    // An underrun resets the queue to one buffer and comes only with DMA status
    `APSS_ASSERT(a_underrun, m_tvalid && res.underrun |-> res.kind == apss_pkg::KIND_DMA_STATUS && res.queued_frames == apss_pkg::pend_t'(apss_pkg::DMA_BUFFER_FRAMES), "bad underrun result")

    // Zero padding comes only with a play verdict and never with trimming
    `APSS_ASSERT(a_pad_play, m_tvalid && res.kind == apss_pkg::KIND_VERDICT && res.zero_frames != '0 |-> res.verdict == apss_pkg::V_PLAY && res.trimmed_frames == '0, "padding without plain play")

endmodule

`default_nettype wire
